>>> rtl/tbht_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the touch button hit test.
package tbht_pkg;

    localparam int RAW_W   = 12;
    localparam int EDGE_W  = 16;
    localparam int ID_W    = 8;
    localparam int PROD_W  = 2 * RAW_W;
    localparam int RECT_W  = 4 * EDGE_W + ID_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_TOUCH = 1'b1;

    typedef enum logic [2:0] {
        REG_CAL_MIN_X     = 3'd0,
        REG_CAL_MAX_X     = 3'd1,
        REG_CAL_MIN_Y     = 3'd2,
        REG_CAL_MAX_Y     = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5
    } reg_idx_t;

    localparam logic [RAW_W-1:0] RST_CAL_MIN_X     = 12'd150;
    localparam logic [RAW_W-1:0] RST_CAL_MAX_X     = 12'd3800;
    localparam logic [RAW_W-1:0] RST_CAL_MIN_Y     = 12'd130;
    localparam logic [RAW_W-1:0] RST_CAL_MAX_Y     = 12'd4000;
    localparam logic [RAW_W-1:0] RST_SCREEN_WIDTH  = 12'd240;
    localparam logic [RAW_W-1:0] RST_SCREEN_HEIGHT = 12'd320;

    typedef struct packed {
        logic [RAW_W-1:0] cal_min_x;
        logic [RAW_W-1:0] cal_max_x;
        logic [RAW_W-1:0] cal_min_y;
        logic [RAW_W-1:0] cal_max_y;
        logic [RAW_W-1:0] screen_width;
        logic [RAW_W-1:0] screen_height;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIVIDE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/tbht_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module tbht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tbht_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module tbht_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tbht_pkg::PROD_W-1:0]  dividend,
    input  logic [tbht_pkg::RAW_W-1:0]   divisor,
    output logic                         busy,
    output logic [tbht_pkg::PROD_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(tbht_pkg::PROD_W + 1);

    logic [tbht_pkg::PROD_W-1:0] quo_reg;
    logic [tbht_pkg::RAW_W-1:0]  rem_reg;
    logic [tbht_pkg::RAW_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic [tbht_pkg::RAW_W:0]    trial;
    logic [tbht_pkg::RAW_W:0]    diff;
    logic                        fits;

    // The partial remainder stays below the divisor, so it fits RAW_W bits.
    assign trial = {rem_reg, quo_reg[tbht_pkg::PROD_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(tbht_pkg::PROD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[tbht_pkg::PROD_W-2:0], fits};
            rem_reg <= fits ? diff[tbht_pkg::RAW_W-1:0] : trial[tbht_pkg::RAW_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/tbht_regs.sv
`timescale 1ns / 1ps
// APB-style register file holding the calibration and screen size settings.
module tbht_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbht_pkg::ADDR_W-1:0]   paddr,
    input  logic [tbht_pkg::DATA_W-1:0]   pwdata,
    output logic [tbht_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output tbht_pkg::cfg_t                cfg
);

    tbht_pkg::cfg_t   cfg_reg;
    tbht_pkg::reg_idx_t idx;
    logic             wr_en;
    logic [tbht_pkg::RAW_W-1:0] wval;
    logic [tbht_pkg::RAW_W-1:0] rval;

    assign idx   = tbht_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en = psel && penable && pwrite;
    assign wval  = pwdata[tbht_pkg::RAW_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_min_x     <= tbht_pkg::RST_CAL_MIN_X;
            cfg_reg.cal_max_x     <= tbht_pkg::RST_CAL_MAX_X;
            cfg_reg.cal_min_y     <= tbht_pkg::RST_CAL_MIN_Y;
            cfg_reg.cal_max_y     <= tbht_pkg::RST_CAL_MAX_Y;
            cfg_reg.screen_width  <= tbht_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= tbht_pkg::RST_SCREEN_HEIGHT;
        end
        else if (wr_en)
        begin
            case (idx)
                tbht_pkg::REG_CAL_MIN_X:     cfg_reg.cal_min_x     <= wval;
                tbht_pkg::REG_CAL_MAX_X:     cfg_reg.cal_max_x     <= wval;
                tbht_pkg::REG_CAL_MIN_Y:     cfg_reg.cal_min_y     <= wval;
                tbht_pkg::REG_CAL_MAX_Y:     cfg_reg.cal_max_y     <= wval;
                tbht_pkg::REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= wval;
                tbht_pkg::REG_SCREEN_HEIGHT: cfg_reg.screen_height <= wval;
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tbht_pkg::REG_CAL_MIN_X:     rval = cfg_reg.cal_min_x;
            tbht_pkg::REG_CAL_MAX_X:     rval = cfg_reg.cal_max_x;
            tbht_pkg::REG_CAL_MIN_Y:     rval = cfg_reg.cal_min_y;
            tbht_pkg::REG_CAL_MAX_Y:     rval = cfg_reg.cal_max_y;
            tbht_pkg::REG_SCREEN_WIDTH:  rval = cfg_reg.screen_width;
            tbht_pkg::REG_SCREEN_HEIGHT: rval = cfg_reg.screen_height;
            default:                     rval = '0;
        endcase
    end

    assign prdata = {{(tbht_pkg::DATA_W - tbht_pkg::RAW_W){1'b0}}, rval};
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

>>> rtl/touch_button_hit_test.sv
`timescale 1ns / 1ps
// Top level of the touch button hit test: sequencer, mapping datapath and button table.
//
// Usage. Input words arrive on in_valid/in_stall and carry either a button to add
// (func = 0) or a touch sample (func = 1). Every accepted word yields exactly one
// result word on out_valid/out_stall: pressed_id and add_refused.
// An add writes the rectangle into the button RAM at the current fill count and
// passes through the finish state to the output register; a full table refuses it.
// A touch sample that is not a new press also goes straight to the finish state.
// A new press maps raw x and y onto the screen with two 12x12 multipliers and two
// 24-step restoring dividers working side by side, then reads the stored buttons
// from the RAM one per cycle; it passes through the multiply, divider start,
// divide, scan and finish states before its result reaches the output register.
// One word is processed at a time; in_stall is low only while the sequencer idles.
// A finished result sits in the output register; if the receiver stalls, the next
// word is still accepted and processed, and waits for the register to free.
// Reset empties the table, clears the press latch, drops out_valid and loads the
// default calibration. The table contents themselves are not cleared.
module touch_button_hit_test #(
    parameter int MAX_BUTTONS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tbht_pkg::ADDR_W-1:0]        paddr,
    input  logic [tbht_pkg::DATA_W-1:0]        pwdata,
    output logic [tbht_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic                               touched,
    input  logic [tbht_pkg::RAW_W-1:0]         raw_x,
    input  logic [tbht_pkg::RAW_W-1:0]         raw_y,
    input  logic signed [tbht_pkg::EDGE_W-1:0] left_edge,
    input  logic signed [tbht_pkg::EDGE_W-1:0] top_edge,
    input  logic signed [tbht_pkg::EDGE_W-1:0] right_edge,
    input  logic signed [tbht_pkg::EDGE_W-1:0] bottom_edge,
    input  logic [tbht_pkg::ID_W-1:0]          button_id,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tbht_pkg::ID_W-1:0]          pressed_id,
    output logic                               add_refused
);

    localparam int AW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
    localparam int CW = $clog2(MAX_BUTTONS + 1);
    localparam int RW = tbht_pkg::RAW_W;
    localparam int PW = tbht_pkg::PROD_W;
    localparam int EW = tbht_pkg::EDGE_W;
    localparam int IW = tbht_pkg::ID_W;

    // Saturate a quotient magnitude with its sign to a signed 16-bit coordinate.
    function automatic logic signed [EW-1:0] sat_axis(input logic neg, input logic [PW-1:0] q);
        logic [PW-1:0] nq;
        nq = ~q + PW'(1);
        if (!neg)
        begin
            sat_axis = (q > PW'(32767)) ? 16'sh7fff : q[EW-1:0];
        end
        else
        begin
            sat_axis = (q > PW'(32768)) ? 16'sh8000 : nq[EW-1:0];
        end
    endfunction

    // Absolute value of a 13-bit signed difference; it always fits RAW_W bits.
    function automatic logic [RW-1:0] mag13(input logic [RW:0] d);
        logic [RW:0] n;
        n = ~d + (RW+1)'(1);
        mag13 = d[RW] ? n[RW-1:0] : d[RW-1:0];
    endfunction

    tbht_pkg::cfg_t   cfg;
    tbht_pkg::state_t state_reg;
    tbht_pkg::state_t state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] scan_addr_reg;
    logic          rd_pending_reg;
    logic          latched_reg;

    logic [RW-1:0] raw_x_reg;
    logic [RW-1:0] raw_y_reg;
    logic [PW-1:0] prod_x_reg;
    logic [PW-1:0] prod_y_reg;
    logic [RW-1:0] den_x_reg;
    logic [RW-1:0] den_y_reg;
    logic          neg_x_reg;
    logic          neg_y_reg;
    logic          zero_x_reg;
    logic          zero_y_reg;
    logic signed [EW-1:0] x_reg;
    logic signed [EW-1:0] y_reg;
    logic [IW-1:0] res_id_reg;
    logic          res_refused_reg;

    logic          out_valid_reg;
    logic [IW-1:0] pressed_id_reg;
    logic          add_refused_reg;

    logic          accept;
    logic          table_full;
    logic          new_press;
    logic          ram_we;
    logic          ram_re;
    logic          div_start;
    logic          div_done;
    logic          scan_issue;
    logic          out_free;
    logic          load_out;

    logic [RW:0]   dx;
    logic [RW:0]   dy;
    logic [RW:0]   ddx;
    logic [RW:0]   ddy;

    logic          busy_x;
    logic          busy_y;
    logic [PW-1:0] quo_x;
    logic [PW-1:0] quo_y;

    logic [tbht_pkg::RECT_W-1:0] wr_rect;
    logic [tbht_pkg::RECT_W-1:0] rd_rect;
    logic signed [EW-1:0] rd_left;
    logic signed [EW-1:0] rd_top;
    logic signed [EW-1:0] rd_right;
    logic signed [EW-1:0] rd_bottom;
    logic [IW-1:0]        rd_id;
    logic                 hit;

    // ---------------------------------------------------------------- config
    tbht_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------------------------------------------------------- control
    assign in_stall   = (state_reg != tbht_pkg::ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign table_full = (count_reg >= CW'(MAX_BUTTONS));
    assign new_press  = (func == tbht_pkg::FUNC_TOUCH) && touched && !latched_reg;
    assign div_done   = !busy_x && !busy_y;
    assign out_free   = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tbht_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = new_press ? tbht_pkg::ST_MUL : tbht_pkg::ST_FINISH;
                end
            end
            tbht_pkg::ST_MUL:    state_next = tbht_pkg::ST_START;
            tbht_pkg::ST_START:  state_next = tbht_pkg::ST_DIVIDE;
            tbht_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = tbht_pkg::ST_SCAN;
                end
            end
            tbht_pkg::ST_SCAN:
            begin
                if (!scan_issue && !rd_pending_reg)
                begin
                    state_next = tbht_pkg::ST_FINISH;
                end
            end
            tbht_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = tbht_pkg::ST_IDLE;
                end
            end
            default: state_next = tbht_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        ram_we     = 1'b0;
        div_start  = 1'b0;
        scan_issue = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            tbht_pkg::ST_IDLE:   ram_we = accept && (func == tbht_pkg::FUNC_ADD) && !table_full;
            tbht_pkg::ST_MUL:    ;
            tbht_pkg::ST_START:  div_start = 1'b1;
            tbht_pkg::ST_DIVIDE: ;
            tbht_pkg::ST_SCAN:   scan_issue = (scan_addr_reg < count_reg);
            tbht_pkg::ST_FINISH: load_out = out_free;
            default:             ;
        endcase
    end

    assign ram_re = scan_issue;

    // Adds only happen in idle and reads only during a scan, so the two never
    // touch the same entry in overlapping cycles.
    always_comb
    begin
        count_next = count_reg;
        if (ram_we)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tbht_pkg::ST_IDLE;
            count_reg      <= '0;
            latched_reg    <= 1'b0;
            rd_pending_reg <= 1'b0;
            scan_addr_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_pending_reg <= scan_issue;
            if (accept && (func == tbht_pkg::FUNC_TOUCH))
            begin
                latched_reg <= touched;
            end
            if (state_reg == tbht_pkg::ST_DIVIDE)
            begin
                scan_addr_reg <= '0;
            end
            else if (scan_issue)
            begin
                scan_addr_reg <= scan_addr_reg + CW'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- mapping
    assign dx  = {1'b0, raw_x_reg} - {1'b0, cfg.cal_min_x};
    assign dy  = {1'b0, raw_y_reg} - {1'b0, cfg.cal_min_y};
    assign ddx = {1'b0, cfg.cal_max_x} - {1'b0, cfg.cal_min_x};
    assign ddy = {1'b0, cfg.cal_max_y} - {1'b0, cfg.cal_min_y};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_x_reg       <= raw_x;
            raw_y_reg       <= raw_y;
            res_id_reg      <= '0;
            res_refused_reg <= (func == tbht_pkg::FUNC_ADD) && table_full;
        end
        if (state_reg == tbht_pkg::ST_MUL)
        begin
            prod_x_reg <= PW'(mag13(dx)) * PW'(cfg.screen_width);
            prod_y_reg <= PW'(mag13(dy)) * PW'(cfg.screen_height);
            den_x_reg  <= mag13(ddx);
            den_y_reg  <= mag13(ddy);
            neg_x_reg  <= dx[RW] ^ ddx[RW];
            neg_y_reg  <= dy[RW] ^ ddy[RW];
            zero_x_reg <= (ddx == '0);
            zero_y_reg <= (ddy == '0);
        end
        if ((state_reg == tbht_pkg::ST_DIVIDE) && div_done)
        begin
            // A zero-width calibration range maps every reading to zero.
            x_reg <= zero_x_reg ? '0 : sat_axis(neg_x_reg, quo_x);
            y_reg <= zero_y_reg ? '0 : sat_axis(neg_y_reg, quo_y);
        end
        if (rd_pending_reg && hit)
        begin
            res_id_reg <= rd_id;
        end
        if (load_out)
        begin
            pressed_id_reg  <= res_id_reg;
            add_refused_reg <= res_refused_reg;
        end
    end

    tbht_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_x_reg),
        .divisor  (den_x_reg),
        .busy     (busy_x),
        .quotient (quo_x)
    );

    tbht_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_y_reg),
        .divisor  (den_y_reg),
        .busy     (busy_y),
        .quotient (quo_y)
    );

    // ---------------------------------------------------------------- table
    assign wr_rect = {left_edge, top_edge, right_edge, bottom_edge, button_id};

    tbht_ram #(
        .WIDTH (tbht_pkg::RECT_W),
        .DEPTH (MAX_BUTTONS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_rect),
        .re    (ram_re),
        .raddr (scan_addr_reg[AW-1:0]),
        .rdata (rd_rect)
    );

    assign rd_left   = rd_rect[4*EW+IW-1:3*EW+IW];
    assign rd_top    = rd_rect[3*EW+IW-1:2*EW+IW];
    assign rd_right  = rd_rect[2*EW+IW-1:EW+IW];
    assign rd_bottom = rd_rect[EW+IW-1:IW];
    assign rd_id     = rd_rect[IW-1:0];

    // Inclusive bounds; later entries overwrite earlier hits, so the last match wins.
    assign hit = (rd_left <= x_reg) && (rd_top <= y_reg)
              && (rd_right >= x_reg) && (rd_bottom >= y_reg);

    // ---------------------------------------------------------------- outputs
    assign out_valid   = out_valid_reg;
    assign pressed_id  = pressed_id_reg;
    assign add_refused = add_refused_reg;

    // ---------------------------------------------------------------- checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BUTTONS))
        else $error("button count beyond table size");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == tbht_pkg::FUNC_ADD) && !table_full
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted add did not extend the table");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(add_refused_reg && (pressed_id_reg != '0)))
        else $error("refused add reported a pressed button");

    a_scan_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tbht_pkg::ST_SCAN) |-> latched_reg)
        else $error("table scan without a latched press");

    a_scan_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tbht_pkg::ST_SCAN) |-> (!busy_x && !busy_y))
        else $error("table scan started before mapping finished");

endmodule
